>>> rtl/core/fpr_pkg.sv
// shared constants and types for the framed packet receiver
`timescale 1ns / 1ps

package fpr_pkg;

  // frame store geometry
  localparam int MAX_FRAME_BYTES = 12;
  localparam int IDX_W           = $clog2(MAX_FRAME_BYTES);
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  // fixed field widths of the result word
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 4;
  localparam int SUM_W   = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register reset values
  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hCC;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hDD;

  // register index, taken from paddr bit 2
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  // frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADSUM   = 2'd1,
    ST_OVERLONG = 2'd2
  } status_t;

endpackage

>>> rtl/core/fpr_frame_ram.sv
// frame store ram: one write port, one read port with registered data
`timescale 1ns / 1ps

module fpr_frame_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [fpr_pkg::IDX_W-1:0]   waddr,
  input  logic [fpr_pkg::BYTE_W-1:0]  wdata,
  input  logic [fpr_pkg::IDX_W-1:0]   raddr,
  output logic [fpr_pkg::BYTE_W-1:0]  rdata
);
  import fpr_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_FRAME_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/framed_packet_receiver.sv
// framed packet receiver top level: byte parser, frame store and word emitter
`timescale 1ns / 1ps

// Takes one received byte per cycle while a frame is being collected. Bytes
// are dropped until one equals head_byte; from there bytes go into a 12-entry
// frame ram and into a 16-bit sum until a byte equal to tail_byte, followed by
// a little-endian checksum. On the high checksum byte, or on a byte that finds
// the store full (overlong, byte dropped), the input stalls and all 12 store
// entries go out as words, zero beyond frame_length, with the frame status.
// Emission reads one entry at a time: a new read waits until the previous
// read's data is registered into the output word, and that word is free or
// being taken. The first word appears once the ending byte has set the emit
// phase and the first read's data is registered; the input stays stalled
// until the last entry's read is issued. Entries past the fill count read as
// zero, so there is no clearing pass after reset or between frames.
module framed_packet_receiver (
  input  logic                          clk,
  input  logic                          rst,
  // received bytes
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  logic [7:0]                    rx_byte,
  // emitted frame words
  output logic                          frame_valid,
  input  logic                          frame_stall,
  output logic [7:0]                    frame_byte,
  output logic [3:0]                    byte_index,
  output logic [3:0]                    frame_length,
  output logic [1:0]                    frame_status,
  output logic                          last_byte,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpr_pkg::PADDR_W-1:0]   paddr,
  input  logic [fpr_pkg::PDATA_W-1:0]   pwdata,
  output logic [fpr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import fpr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_CKLO,
    PH_CKHI,
    PH_EMIT
  } phase_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_FRAME_BYTES);

  phase_t               phase;
  logic [BYTE_W-1:0]    head_byte;
  logic [BYTE_W-1:0]    tail_byte;
  logic [CNT_W-1:0]     stored_count;
  logic [SUM_W-1:0]     running_sum;
  logic [BYTE_W-1:0]    checksum_low;
  status_t              status;

  // emission read pipeline
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_pend;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_zero;
  logic                 rd_last;
  logic [CNT_W-1:0]     em_len;
  status_t              em_status;

  logic                 rx_accept;
  logic                 out_take;
  logic                 rd_issue;
  logic                 cfg_write;
  logic                 head_hit;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [BYTE_W-1:0]    ram_rdata;
  logic [SUM_W-1:0]     sum_next;
  logic [SUM_W-1:0]     check_word;
  logic [IDX_W+FIELD_W-1:0] idx_ext;
  logic [CNT_W+FIELD_W-1:0] len_ext;

  // handshakes
  assign rx_stall  = (phase == PH_EMIT);
  assign rx_accept = rx_valid & ~rx_stall;
  assign out_take  = frame_valid & ~frame_stall;
  assign rd_issue  = (phase == PH_EMIT) & ~rd_pend & (~frame_valid | out_take);
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_HEAD: prdata = {{(PDATA_W-BYTE_W){1'b0}}, head_byte};
      REG_TAIL: prdata = {{(PDATA_W-BYTE_W){1'b0}}, tail_byte};
      default:  prdata = '0;
    endcase
  end

  // datapath helpers
  assign head_hit   = (rx_byte == head_byte);
  assign sum_next   = running_sum + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
  assign check_word = {rx_byte, checksum_low};
  assign idx_ext    = {{FIELD_W{1'b0}}, rd_idx_q};
  assign len_ext    = {{FIELD_W{1'b0}}, em_len};

  // store write: head in idle, body bytes while there is room
  assign ram_we    = rx_accept & (((phase == PH_IDLE) & head_hit) |
                                  ((phase == PH_BODY) & (stored_count != FULL_CNT)));
  assign ram_waddr = (phase == PH_IDLE) ? '0 : stored_count[IDX_W-1:0];

  fpr_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // phase sequencer, frame state and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      head_byte    <= HEAD_RESET;
      tail_byte    <= TAIL_RESET;
      stored_count <= '0;
      running_sum  <= '0;
      checksum_low <= '0;
      rd_idx       <= '0;
      rd_pend      <= 1'b0;
      frame_valid  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_write) begin
        unique case (paddr[2])
          REG_HEAD: head_byte <= pwdata[BYTE_W-1:0];
          REG_TAIL: tail_byte <= pwdata[BYTE_W-1:0];
          default:  head_byte <= head_byte;
        endcase
      end

      // output word register
      if (out_take) begin
        frame_valid <= 1'b0;
      end
      if (rd_pend) begin
        frame_valid  <= 1'b1;
        frame_byte   <= rd_zero ? '0 : ram_rdata;
        byte_index   <= idx_ext[FIELD_W-1:0];
        frame_length <= len_ext[FIELD_W-1:0];
        frame_status <= em_status;
        last_byte    <= rd_last;
        rd_pend      <= 1'b0;
      end

      unique case (phase)
        PH_IDLE: begin
          if (rx_accept && head_hit) begin
            stored_count <= CNT_W'(1);
            running_sum  <= {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
            phase        <= PH_BODY;
          end
        end
        PH_BODY: begin
          if (rx_accept) begin
            if (stored_count == FULL_CNT) begin
              // overlong: byte dropped, store goes out as is
              status <= ST_OVERLONG;
              rd_idx <= '0;
              phase  <= PH_EMIT;
            end else begin
              stored_count <= stored_count + CNT_W'(1);
              running_sum  <= sum_next;
              if (rx_byte == tail_byte) begin
                phase <= PH_CKLO;
              end
            end
          end
        end
        PH_CKLO: begin
          if (rx_accept) begin
            checksum_low <= rx_byte;
            phase        <= PH_CKHI;
          end
        end
        PH_CKHI: begin
          if (rx_accept) begin
            status <= (check_word == running_sum) ? ST_OK : ST_BADSUM;
            rd_idx <= '0;
            phase  <= PH_EMIT;
          end
        end
        PH_EMIT: begin
          // one read per free output slot; clear frame after the last read
          if (rd_issue) begin
            rd_pend   <= 1'b1;
            rd_idx_q  <= rd_idx;
            rd_zero   <= (CNT_W'(rd_idx) >= stored_count);
            rd_last   <= (rd_idx == LAST_IDX);
            em_len    <= stored_count;
            em_status <= status;
            if (rd_idx == LAST_IDX) begin
              stored_count <= '0;
              running_sum  <= '0;
              checksum_low <= '0;
              rd_idx       <= '0;
              phase        <= PH_IDLE;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/fpr_checker.sv
// port-level checker for the framed packet receiver, with its bind
`timescale 1ns / 1ps

module fpr_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  input  logic                          frame_stall,
  input  logic [7:0]                    frame_byte,
  input  logic [3:0]                    byte_index,
  input  logic [3:0]                    frame_length,
  input  logic [1:0]                    frame_status,
  input  logic                          last_byte
);
  import fpr_pkg::*;

  localparam logic [3:0] LAST_IDX = 4'(MAX_FRAME_BYTES - 1);

  logic [3:0] exp_idx;

  // expected position of the next word in the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (frame_valid && !frame_stall) begin
      exp_idx <= last_byte ? 4'd0 : exp_idx + 4'd1;
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_stall |=> frame_valid && $stable(frame_byte) &&
    $stable(byte_index) && $stable(frame_status))
    else $error("stalled frame word changed");

  // words come out in store order, no gap and no repeat
  a_order: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> byte_index == exp_idx)
    else $error("frame word out of order");

  // last flag marks the final store entry
  a_last: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> last_byte == (byte_index == LAST_IDX))
    else $error("last_byte on wrong entry");

  // padding past the received length is zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    frame_valid && (byte_index >= frame_length) |-> frame_byte == 8'd0)
    else $error("padding entry not zero");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (.*);

>>> bench/tb_framed_packet_receiver.sv
// testbench for the framed packet receiver: directed byte table, random frames, word checker
`timescale 1ns / 1ps

module tb_framed_packet_receiver;
  import fpr_pkg::*;

  localparam int FRAME_N       = MAX_FRAME_BYTES;
  localparam int SETTLE_CYCLES = 30;
  localparam int BURST_CYCLES  = 400;
  localparam int PRINT_CAP     = 50;
  localparam int SCRIPT_N      = 26;

  // receive phases of the frame parser
  typedef enum logic [1:0] {
    AWAIT_HEAD,
    IN_BODY,
    SUM_LOW,
    SUM_HIGH
  } rx_phase_t;

  // one emitted frame word
  typedef struct {
    logic [7:0] data;
    logic [3:0] index;
    logic [3:0] length;
    status_t    status;
    logic       is_last;
  } frame_word_t;

  // one directed input byte; length and status are spelled out where pinned
  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    logic [3:0] length;
    status_t    status;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                rx_valid;
  logic                rx_stall;
  logic [7:0]          rx_byte;
  logic                frame_valid;
  logic                frame_stall;
  logic [7:0]          frame_byte;
  logic [3:0]          byte_index;
  logic [3:0]          frame_length;
  logic [1:0]          frame_status;
  logic                last_byte;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // parser copy: registers, phase, store and sum
  logic [7:0]          head_cfg;
  logic [7:0]          tail_cfg;
  rx_phase_t           parse_phase;
  logic [CNT_W-1:0]    parse_count;
  logic [SUM_W-1:0]    parse_sum;
  logic [7:0]          parse_sum_lo;
  logic [7:0]          parse_store [FRAME_N];
  frame_word_t         pending_words [$];

  int                  mismatch_count;
  int                  useful_items;
  bit                  gaps_on;
  int                  burst_cycles;

  // directed bytes under the reset framing (head 0xCC, tail 0xDD)
  script_row_t script [SCRIPT_N] = '{
    // noise before any head, both extremes
    '{8'h00, 1'b0, 4'd0,  ST_OK},
    '{8'hFF, 1'b0, 4'd0,  ST_OK},
    // head, extreme body bytes, tail, good sum 0x02A8
    '{8'hCC, 1'b0, 4'd0,  ST_OK},
    '{8'h00, 1'b0, 4'd0,  ST_OK},
    '{8'hFF, 1'b0, 4'd0,  ST_OK},
    '{8'hDD, 1'b0, 4'd0,  ST_OK},
    '{8'hA8, 1'b0, 4'd0,  ST_OK},
    '{8'h02, 1'b1, 4'd4,  ST_OK},
    // shortest frame, wrong sum
    '{8'hCC, 1'b0, 4'd0,  ST_OK},
    '{8'hDD, 1'b0, 4'd0,  ST_OK},
    '{8'h00, 1'b0, 4'd0,  ST_OK},
    '{8'h00, 1'b1, 4'd2,  ST_BADSUM},
    // full store with head value inside the body, then a tail that finds it full
    '{8'hCC, 1'b0, 4'd0,  ST_OK},
    '{8'hCC, 1'b0, 4'd0,  ST_OK},
    '{8'h01, 1'b0, 4'd0,  ST_OK},
    '{8'h02, 1'b0, 4'd0,  ST_OK},
    '{8'h04, 1'b0, 4'd0,  ST_OK},
    '{8'h08, 1'b0, 4'd0,  ST_OK},
    '{8'h10, 1'b0, 4'd0,  ST_OK},
    '{8'h20, 1'b0, 4'd0,  ST_OK},
    '{8'h40, 1'b0, 4'd0,  ST_OK},
    '{8'h80, 1'b0, 4'd0,  ST_OK},
    '{8'hFF, 1'b0, 4'd0,  ST_OK},
    '{8'h7E, 1'b0, 4'd0,  ST_OK},
    '{8'hDD, 1'b1, 4'd12, ST_OVERLONG},
    // stray byte back in the idle phase
    '{8'h34, 1'b0, 4'd0,  ST_OK}
  };

  framed_packet_receiver dut (
    .clk,
    .rst,
    .rx_valid,
    .rx_stall,
    .rx_byte,
    .frame_valid,
    .frame_stall,
    .frame_byte,
    .byte_index,
    .frame_length,
    .frame_status,
    .last_byte,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // clock
  always #4 clk = ~clk;

  task automatic note_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic clear_parser();
    int k;
    parse_phase  = AWAIT_HEAD;
    parse_count  = '0;
    parse_sum    = '0;
    parse_sum_lo = '0;
    for (k = 0; k < FRAME_N; k++) parse_store[k] = '0;
  endtask

  // store a byte and add it to the sum while there is room
  task automatic keep_byte(input logic [7:0] b);
    if (parse_count < FRAME_N) begin
      parse_store[parse_count] = b;
      parse_count++;
      parse_sum += SUM_W'(b);
    end
  endtask

  // queue the whole zero padded store, then start over
  task automatic queue_frame(input status_t st, input bit pinned,
                             input logic [3:0] pin_len, input status_t pin_st);
    frame_word_t w;
    int k;
    for (k = 0; k < FRAME_N; k++) begin
      w.data    = parse_store[k];
      w.index   = 4'(k);
      w.length  = pinned ? pin_len : 4'(parse_count);
      w.status  = pinned ? pin_st : st;
      w.is_last = (k == FRAME_N - 1);
      pending_words.push_back(w);
    end
    clear_parser();
  endtask

  // advance the parser copy by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input bit pinned,
                            input logic [3:0] pin_len, input status_t pin_st,
                            output bit counted);
    counted = 1'b1;
    case (parse_phase)
      AWAIT_HEAD: begin
        if (b == head_cfg) begin
          keep_byte(b);
          parse_phase = IN_BODY;
        end else begin
          counted = 1'b0;
        end
      end
      IN_BODY: begin
        // full store wins over the tail check; the byte is dropped
        if (parse_count >= FRAME_N) begin
          queue_frame(ST_OVERLONG, pinned, pin_len, pin_st);
        end else begin
          keep_byte(b);
          if (b == tail_cfg) parse_phase = SUM_LOW;
        end
      end
      SUM_LOW: begin
        parse_sum_lo = b;
        parse_phase  = SUM_HIGH;
      end
      default: begin
        queue_frame(({b, parse_sum_lo} == parse_sum) ? ST_OK : ST_BADSUM,
                    pinned, pin_len, pin_st);
      end
    endcase
  endtask

  // offer one byte and hold it until the block takes it
  task automatic offer_byte(input logic [7:0] b, input bit pinned,
                            input logic [3:0] pin_len, input status_t pin_st);
    bit counted;
    while (gaps_on && $urandom_range(99) < 11) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    parse_byte(b, pinned, pin_len, pin_st, counted);
    if (counted) useful_items++;
    @(negedge clk);
  endtask

  task automatic offer(input logic [7:0] b);
    offer_byte(b, 1'b0, 4'd0, ST_OK);
  endtask

  function automatic logic [7:0] body_pick();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == tail_cfg) b ^= 8'h01;
    return b;
  endfunction

  // one random frame: mostly well formed, some overlong, some with a bad sum
  task automatic send_random_frame();
    logic [15:0] sum;
    logic [7:0]  b;
    int          kind;
    int          n;
    int          k;
    kind = $urandom_range(99);
    sum  = 16'(head_cfg);
    offer(head_cfg);
    if (kind < 12) begin
      for (k = 0; k < FRAME_N - 1; k++) offer(body_pick());
      offer(($urandom_range(2) == 0) ? tail_cfg : 8'($urandom));
      // the would-be checksum lands in the idle phase
      offer(8'($urandom));
      offer(8'($urandom));
    end else begin
      n = (kind < 22) ? FRAME_N - 2 : $urandom_range(0, 6);
      for (k = 0; k < n; k++) begin
        b = body_pick();
        sum += 16'(b);
        offer(b);
      end
      sum += 16'(tail_cfg);
      offer(tail_cfg);
      if (kind >= 90) sum ^= 16'(1 << $urandom_range(15));
      offer(sum[7:0]);
      offer(sum[15:8]);
    end
  endtask

  task automatic run_random_phase(input int target);
    int start;
    start = useful_items;
    while (useful_items - start < target) begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) offer(8'($urandom));
      send_random_frame();
    end
  endtask

  // stop sending and wait for every queued word, then let the block settle
  task automatic drain();
    rx_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write followed by a read back
  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_HEAD) head_cfg = value;
    else tail_cfg = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value)
      note_mismatch($sformatf("register %0d reads %h, written %h", idx, prdata[7:0], value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_framing(input logic [7:0] head, input logic [7:0] tail);
    write_reg(REG_HEAD, head);
    write_reg(REG_TAIL, tail);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    frame_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst_cycles > 0) begin
        frame_stall <= 1'b1;
        burst_cycles--;
      end else begin
        frame_stall <= gaps_on && ($urandom_range(99) < 11);
      end
    end
  end

  // compare each accepted word with the oldest queued one
  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && frame_valid && !frame_stall) begin
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word: byte %h index %0d length %0d status %0d",
                                frame_byte, byte_index, frame_length, frame_status));
      end else begin
        want = pending_words.pop_front();
        if (frame_byte !== want.data || byte_index !== want.index ||
            frame_length !== want.length || frame_status !== want.status ||
            last_byte !== want.is_last)
          note_mismatch($sformatf(
            "word got %h/%0d/%0d/%0d/%0d, want %h/%0d/%0d/%0d/%0d",
            frame_byte, byte_index, frame_length, frame_status, last_byte,
            want.data, want.index, want.length, want.status, want.is_last));
      end
    end
  end

  // run limit
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  // main sequence
  initial begin
    int i;
    rst            = 1'b1;
    rx_valid       = 1'b0;
    rx_byte        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    gaps_on        = 1'b1;
    burst_cycles   = 0;
    mismatch_count = 0;
    useful_items   = 0;
    head_cfg       = HEAD_RESET;
    tail_cfg       = TAIL_RESET;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (i = 0; i < SCRIPT_N; i++)
      offer_byte(script[i].rx, script[i].pinned, script[i].length, script[i].status);
    drain();

    // extreme framing, with a full pause in the middle
    set_framing(8'h00, 8'hFF);
    run_random_phase(20);
    drain();
    run_random_phase(20);
    drain();

    // reversed extremes while the output holds off for a long stretch
    set_framing(8'hFF, 8'h00);
    burst_cycles = BURST_CYCLES;
    run_random_phase(40);
    drain();

    // head and tail share one value
    set_framing(8'h5A, 8'h5A);
    run_random_phase(40);
    drain();

    // random framing with no idling on either side
    gaps_on = 1'b0;
    set_framing(8'($urandom), 8'($urandom));
    run_random_phase(40);
    drain();
    gaps_on = 1'b1;

    // back to the reset framing
    set_framing(HEAD_RESET, TAIL_RESET);
    run_random_phase(40);
    drain();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_frame_ram.sv
rtl/core/framed_packet_receiver.sv
rtl/core/fpr_checker.sv
bench/tb_framed_packet_receiver.sv
